FILE: rtl/core/fia_pkg.sv
// fia_pkg: shared types and constants for the free id allocator
// holds request and status codes, controller state and command/status structs
// no dependencies
package fia_pkg;

  // default sizing, overridable through top-level parameters
  localparam int ID_COUNT_DEF  = 256;
  localparam int MASK_BITS_DEF = 32;

  // fixed port widths
  localparam int OP_W     = 2;
  localparam int IDENT_W  = 8;
  localparam int MASK_W   = 32;
  localparam int STATUS_W = 2;
  localparam int LIVE_W   = 9;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE     = 2'd1,
    OP_SET_MASK = 2'd2,
    OP_GET_MASK = 2'd3
  } fia_op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_NO_FREE   = 2'd1,
    STS_NONE_LIVE = 2'd2,
    STS_RANGE     = 2'd3
  } fia_status_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2
  } fia_state_t;

  // controller -> datapath
  typedef struct packed {
    logic sweep;
    logic capture;
    logic exec;
  } fia_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sweep_last;
  } fia_stat_t;

endpackage

FILE: rtl/core/fia_ram.sv
// fia_ram: generic single-write, single-read ram with registered read data
// used for the free ring and the mask table
// no dependencies
module fia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/fia_ctrl.sv
// fia_ctrl: request sequencer for the free id allocator
// runs the post-reset clearing pass, then a capture step and an execute step per request
// depends on fia_pkg
module fia_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  fia_pkg::fia_stat_t stat,
  output logic               busy,
  output fia_pkg::fia_cmd_t  cmd
);

  fia_pkg::fia_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fia_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fia_pkg::ST_CLEAR: begin
        if (stat.sweep_last) begin
          state_nxt = fia_pkg::ST_IDLE;
        end
      end
      fia_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = fia_pkg::ST_EXEC;
        end
      end
      fia_pkg::ST_EXEC: begin
        state_nxt = fia_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = fia_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      fia_pkg::ST_CLEAR: begin
        cmd.sweep = 1'b1;
      end
      fia_pkg::ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      fia_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: rtl/core/fia_datapath.sv
// fia_datapath: free ring, mask table, pointers, live count and result registers
// ram reads are issued in the capture cycle, state updates in the execute cycle
// depends on fia_pkg and fia_ram
module fia_datapath #(
  parameter int ID_COUNT  = fia_pkg::ID_COUNT_DEF,
  parameter int MASK_BITS = fia_pkg::MASK_BITS_DEF,
  localparam int ID_W = $clog2(ID_COUNT)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fia_pkg::fia_cmd_t              cmd,
  output fia_pkg::fia_stat_t             stat,
  input  logic [fia_pkg::OP_W-1:0]       in_operation,
  input  logic [fia_pkg::IDENT_W-1:0]    in_ident,
  input  logic [fia_pkg::MASK_W-1:0]     in_mask_in,
  output logic                           out_valid,
  output logic [fia_pkg::STATUS_W-1:0]   out_status,
  output logic [fia_pkg::IDENT_W-1:0]    out_ident_out,
  output logic [fia_pkg::MASK_W-1:0]     out_mask_out,
  output logic [fia_pkg::LIVE_W-1:0]     out_live_total
);

  // stored mask width: bits above the input word are always zero
  localparam int MW    = (MASK_BITS < fia_pkg::MASK_W) ? MASK_BITS : fia_pkg::MASK_W;
  localparam int CNT_W = $clog2(ID_COUNT + 1);
  localparam int RW    = ((ID_W > fia_pkg::IDENT_W) ? ID_W : fia_pkg::IDENT_W) + 1;

  logic [ID_W-1:0]  head_r, head_nxt;
  logic [ID_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0] live_r, live_nxt;
  logic [ID_W-1:0]  sweep_r, sweep_nxt;

  // captured request
  fia_pkg::fia_op_t op_r;
  logic [fia_pkg::IDENT_W-1:0] ident_r;
  logic [ID_W-1:0]             idx_r;
  logic [MW-1:0]               mask_r;
  logic                        in_range_r;

  logic                        out_valid_r;
  logic [fia_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [fia_pkg::IDENT_W-1:0]  ident_out_r, ident_out_nxt;
  logic [fia_pkg::MASK_W-1:0]   mask_out_r, mask_out_nxt;
  logic [fia_pkg::LIVE_W-1:0]   live_total_r;

  logic            ring_we;
  logic [ID_W-1:0] ring_waddr, ring_wdata, ring_rdata;
  logic            mask_we;
  logic [ID_W-1:0] mask_waddr, mask_raddr;
  logic [MW-1:0]   mask_wdata, mask_rdata;

  logic full, alloc_ok, free_ok, set_ok, get_ok;

  function automatic logic [ID_W-1:0] wrap_inc(input logic [ID_W-1:0] p);
    logic [ID_W-1:0] q;
    if (p == ID_W'(ID_COUNT - 1)) begin
      q = '0;
    end else begin
      q = p + 1'b1;
    end
    return q;
  endfunction

  assign stat.sweep_last = (sweep_r == ID_W'(ID_COUNT - 1));
  assign mask_raddr      = ID_W'(in_ident);

  assign full     = (live_r == CNT_W'(ID_COUNT));
  assign alloc_ok = cmd.exec && (op_r == fia_pkg::OP_ALLOC) && !full;
  assign free_ok  = cmd.exec && (op_r == fia_pkg::OP_FREE) && (live_r != '0) && in_range_r;
  assign set_ok   = cmd.exec && (op_r == fia_pkg::OP_SET_MASK) && in_range_r;
  assign get_ok   = (op_r == fia_pkg::OP_GET_MASK) && in_range_r;

  // sweep loads ring[i] = i and clears the mask table
  always_comb begin
    ring_we    = cmd.sweep || free_ok;
    ring_waddr = cmd.sweep ? sweep_r : wrap_inc(tail_r);
    ring_wdata = cmd.sweep ? sweep_r : idx_r;
    mask_we    = cmd.sweep || free_ok || set_ok;
    mask_waddr = cmd.sweep ? sweep_r : idx_r;
    mask_wdata = (cmd.sweep || free_ok) ? '0 : mask_r;
  end

  fia_ram #(.WIDTH(ID_W), .DEPTH(ID_COUNT)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .raddr (head_r),
    .rdata (ring_rdata)
  );

  fia_ram #(.WIDTH(MW), .DEPTH(ID_COUNT)) u_mask (
    .clk   (clk),
    .we    (mask_we),
    .waddr (mask_waddr),
    .wdata (mask_wdata),
    .raddr (mask_raddr),
    .rdata (mask_rdata)
  );

  always_comb begin
    sweep_nxt = cmd.sweep ? wrap_inc(sweep_r) : sweep_r;
    head_nxt  = alloc_ok ? wrap_inc(head_r) : head_r;
    tail_nxt  = free_ok ? wrap_inc(tail_r) : tail_r;
    live_nxt  = live_r;
    if (alloc_ok) begin
      live_nxt = live_r + 1'b1;
    end else if (free_ok) begin
      live_nxt = live_r - 1'b1;
    end
  end

  always_comb begin
    status_nxt    = fia_pkg::STS_OK;
    ident_out_nxt = ident_r;
    mask_out_nxt  = '0;
    case (op_r)
      fia_pkg::OP_ALLOC: begin
        if (full) begin
          status_nxt    = fia_pkg::STS_NO_FREE;
          ident_out_nxt = '0;
        end else begin
          ident_out_nxt = fia_pkg::IDENT_W'(ring_rdata);
        end
      end
      fia_pkg::OP_FREE: begin
        // empty check wins over range check
        if (live_r == '0) begin
          status_nxt = fia_pkg::STS_NONE_LIVE;
        end else if (!in_range_r) begin
          status_nxt = fia_pkg::STS_RANGE;
        end
      end
      fia_pkg::OP_SET_MASK: begin
        if (!in_range_r) begin
          status_nxt = fia_pkg::STS_RANGE;
        end
      end
      fia_pkg::OP_GET_MASK: begin
        if (!in_range_r) begin
          status_nxt = fia_pkg::STS_RANGE;
        end
        if (get_ok) begin
          mask_out_nxt = fia_pkg::MASK_W'(mask_rdata);
        end
      end
      default: begin
        status_nxt = fia_pkg::STS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= ID_W'(ID_COUNT - 1);
      live_r      <= '0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      live_r      <= live_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= fia_pkg::fia_op_t'(in_operation);
      ident_r    <= in_ident;
      idx_r      <= ID_W'(in_ident);
      mask_r     <= MW'(in_mask_in);
      in_range_r <= (RW'(in_ident) < RW'(ID_COUNT));
    end
    if (cmd.exec) begin
      status_r     <= status_nxt;
      ident_out_r  <= ident_out_nxt;
      mask_out_r   <= mask_out_nxt;
      live_total_r <= fia_pkg::LIVE_W'(live_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_ident_out  = ident_out_r;
  assign out_mask_out   = mask_out_r;
  assign out_live_total = live_total_r;

endmodule

FILE: rtl/core/free_id_allocator_with_masks.sv
// free_id_allocator_with_masks: top level of the free-ring id allocator with per-id masks
// ties the sequencer to the datapath; depends on fia_pkg, fia_ctrl, fia_datapath
//
//   channel  ports                                         transfer when
//   request  in_operation, in_ident, in_mask_in            start && !busy
//   result   out_status, out_ident_out, out_mask_out,      out_valid
//            out_live_total
//
// each request has a capture step for the registered ram reads (ring head and mask
// entry), then an execute step that updates pointers, count and rams; busy is high
// in the execute step. the result shows for one cycle after that, while the next
// request may be taken. after reset a clearing pass refills the ring and zeros
// the mask table with busy high. the receiver cannot stall results.
module free_id_allocator_with_masks #(
  parameter int ID_COUNT  = fia_pkg::ID_COUNT_DEF,
  parameter int MASK_BITS = fia_pkg::MASK_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [fia_pkg::OP_W-1:0]     in_operation,
  input  logic [fia_pkg::IDENT_W-1:0]  in_ident,
  input  logic [fia_pkg::MASK_W-1:0]   in_mask_in,
  output logic                         out_valid,
  output logic [fia_pkg::STATUS_W-1:0] out_status,
  output logic [fia_pkg::IDENT_W-1:0]  out_ident_out,
  output logic [fia_pkg::MASK_W-1:0]   out_mask_out,
  output logic [fia_pkg::LIVE_W-1:0]   out_live_total
);

  fia_pkg::fia_cmd_t  cmd;
  fia_pkg::fia_stat_t stat;

  fia_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  fia_datapath #(
    .ID_COUNT  (ID_COUNT),
    .MASK_BITS (MASK_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_operation   (in_operation),
    .in_ident       (in_ident),
    .in_mask_in     (in_mask_in),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_ident_out  (out_ident_out),
    .out_mask_out   (out_mask_out),
    .out_live_total (out_live_total)
  );

  // an accepted request is executed in the very next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> cmd.exec)
    else $error("accepted request not executed");

  // one result strobe per execute cycle, nothing else
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(cmd.exec))
    else $error("result strobe does not follow execute");

  // sweep never overlaps execute or capture
  a_no_sweep_exec: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.sweep && (cmd.exec || cmd.capture)))
    else $error("request handled during clearing pass");

  // a refused allocate hands out zero
  a_fail_alloc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == fia_pkg::STS_NO_FREE) |-> out_ident_out == '0)
    else $error("failed allocate returned an id");

endmodule
